// File: sv/rtwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtwa_pkg
// Types and constants shared by the rain tip window accumulator modules.
// ----------------------------------------------------------------------------
package rtwa_pkg;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_WINDOW   = 2'd1;
	localparam logic [1:0] REG_RAIN     = 2'd2;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd500;
	localparam logic [31:0] WINDOW_RESET   = 32'd3600000;
	localparam logic [7:0]  RAIN_RESET     = 8'd11;

	localparam logic [8:0]  HOUR_TIPS_MAX = 9'h1FF;
	localparam logic [15:0] HOUR_RAIN_MAX = 16'hFFFF;

	typedef struct packed {
		logic        command;
		logic [31:0] time_ms;
		logic [4:0]  day_of_month;
	} rtwa_in_t;

	typedef struct packed {
		logic [8:0]  hour_tips;
		logic [15:0] hour_rain_milli;
		logic [31:0] day_rain_milli;
		logic        tip_accepted;
		logic        overflow_flag;
	} rtwa_out_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [31:0] window_ms;
		logic [7:0]  rain_per_tip;
	} rtwa_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_UPDATE,
		ST_RESULT
	} rtwa_state_t;

endpackage
`default_nettype wire

// File: sv/rtwa_ring_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtwa_ring_mem
// Tip time store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtwa_ring_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: sv/rtwa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtwa_ctrl
// Sequencer: expires old tips from the ring, applies a tip and forms the result.
// ----------------------------------------------------------------------------
module rtwa_ctrl #(
	parameter int RING_DEPTH = 256,
	parameter int AW         = 8,
	parameter int CW         = 9
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rtwa_pkg::rtwa_cfg_t cfg,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire rtwa_pkg::rtwa_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output rtwa_pkg::rtwa_out_t      out_data,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic [31:0]              mem_wdata,
	output logic                     mem_re,
	output logic [AW-1:0]            mem_raddr,
	input  wire logic [31:0]         mem_rdata
);

	localparam int SW = AW + 1;
	localparam int PW = CW + 8;
	localparam int XW = PW + 16;
	localparam int TW = CW + 9;

	rtwa_pkg::rtwa_state_t state_q, state_d;
	rtwa_pkg::rtwa_in_t    item_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [31:0]   last_tip_q;
	logic [4:0]    prev_day_q;
	logic [31:0]   day_total_q;
	logic          accepted_q;
	logic          overflow_q;
	logic          out_valid_q;
	rtwa_pkg::rtwa_out_t out_q;

	logic          in_fire;
	logic          expire;
	logic          accept;
	logic          full;
	logic          out_free;
	logic [31:0]   elapsed;
	logic [31:0]   age;
	logic [AW-1:0] head_next;
	logic [SW-1:0] slot_sum;
	logic [AW-1:0] slot;
	logic [31:0]   day_base;
	logic [32:0]   day_sum;
	logic [PW-1:0] prod;
	logic [XW-1:0] prod_x;
	logic [TW-1:0] tips_x;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign age      = item_q.time_ms - mem_rdata;
	assign expire   = age > cfg.window_ms;
	assign elapsed  = item_q.time_ms - last_tip_q;
	assign accept   = item_q.command && (elapsed > {16'd0, cfg.debounce_ms});
	assign full     = count_q == CW'(RING_DEPTH);
	assign head_next = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);

	// With a full ring the oldest entry is overwritten in place.
	assign slot_sum = SW'(head_q) + SW'(count_q);
	always_comb begin
		if (full) begin
			slot = head_q;
		end else if (slot_sum >= SW'(RING_DEPTH)) begin
			slot = AW'(slot_sum - SW'(RING_DEPTH));
		end else begin
			slot = slot_sum[AW-1:0];
		end
	end

	assign day_base = (item_q.day_of_month != prev_day_q) ? 32'd0 : day_total_q;
	assign day_sum  = {1'b0, day_base} + 33'(cfg.rain_per_tip);
	assign prod     = PW'(count_q) * PW'(cfg.rain_per_tip);
	assign prod_x   = XW'(prod);
	assign tips_x   = TW'(count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rtwa_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = rtwa_pkg::ST_READ;
				end
			end
			rtwa_pkg::ST_READ: begin
				state_d = (count_q != '0) ? rtwa_pkg::ST_CHECK : rtwa_pkg::ST_UPDATE;
			end
			rtwa_pkg::ST_CHECK: begin
				state_d = expire ? rtwa_pkg::ST_READ : rtwa_pkg::ST_UPDATE;
			end
			rtwa_pkg::ST_UPDATE: begin
				state_d = rtwa_pkg::ST_RESULT;
			end
			rtwa_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = rtwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtwa_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		case (state_q)
			rtwa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			rtwa_pkg::ST_READ: begin
				mem_re = count_q != '0;
			end
			rtwa_pkg::ST_UPDATE: begin
				mem_we = accept;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign mem_raddr = head_q;
	assign mem_waddr = slot;
	assign mem_wdata = item_q.time_ms;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			last_tip_q  <= '0;
			prev_day_q  <= '0;
			day_total_q <= '0;
			accepted_q  <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			if (state_q == rtwa_pkg::ST_CHECK && expire) begin
				head_q  <= head_next;
				count_q <= count_q - CW'(1);
			end
			if (state_q == rtwa_pkg::ST_UPDATE) begin
				accepted_q <= accept;
				overflow_q <= accept && full;
				if (accept) begin
					if (full) begin
						head_q <= head_next;
					end else begin
						count_q <= count_q + CW'(1);
					end
					last_tip_q  <= item_q.time_ms;
					prev_day_q  <= item_q.day_of_month;
					day_total_q <= day_sum[32] ? '1 : day_sum[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rtwa_pkg::ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtwa_pkg::ST_RESULT && out_free) begin
			out_q.hour_tips <= (tips_x > TW'(rtwa_pkg::HOUR_TIPS_MAX)) ?
				rtwa_pkg::HOUR_TIPS_MAX : tips_x[8:0];
			out_q.hour_rain_milli <= (prod_x > XW'(rtwa_pkg::HOUR_RAIN_MAX)) ?
				rtwa_pkg::HOUR_RAIN_MAX : prod_x[15:0];
			out_q.day_rain_milli <= day_total_q;
			out_q.tip_accepted   <= accepted_q;
			out_q.overflow_flag  <= overflow_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_DEPTH))
		else $error("ring count exceeds ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(RING_DEPTH - 1))
		else $error("ring head outside ring");

	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtwa_pkg::ST_CHECK |-> $past(state_q) == rtwa_pkg::ST_READ)
		else $error("entry examined without a read");

	a_overflow_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtwa_pkg::ST_UPDATE && accept && full |=> count_q == $past(count_q))
		else $error("overwrite of oldest entry changed the count");

	a_tip_time_kept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtwa_pkg::ST_UPDATE && accept |=> last_tip_q == $past(item_q.time_ms))
		else $error("accepted tip time not recorded");

endmodule
`default_nettype wire

// File: sv/rain_tip_window_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rain_tip_window_accumulator
// Tipping bucket rain gauge counter with a sliding time window and a day total.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives one result. After an item is
// accepted the block reads the oldest stored tip time from the ring memory and
// compares its age with window_ms in the READ and CHECK states for each
// examined entry, repeating while entries expire; an empty ring goes straight
// on to UPDATE. Then UPDATE applies the tip and RESULT forms the result. The
// ring memory has a single read port with registered read data. A finished
// result sits in an output register; while it is stalled the next item is
// still accepted and carried up to its own result, where it waits, and the
// input stalls until the output register is free again. The ring needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module rain_tip_window_accumulator #(
	parameter int RING_DEPTH = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write_en,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire rtwa_pkg::rtwa_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output rtwa_pkg::rtwa_out_t      out_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);

	rtwa_pkg::rtwa_cfg_t cfg_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= rtwa_pkg::DEBOUNCE_RESET;
			cfg_q.window_ms    <= rtwa_pkg::WINDOW_RESET;
			cfg_q.rain_per_tip <= rtwa_pkg::RAIN_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				rtwa_pkg::REG_DEBOUNCE: cfg_q.debounce_ms  <= cfg_data[15:0];
				rtwa_pkg::REG_WINDOW:   cfg_q.window_ms    <= cfg_data;
				rtwa_pkg::REG_RAIN:     cfg_q.rain_per_tip <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rtwa_ctrl #(
		.RING_DEPTH(RING_DEPTH),
		.AW        (AW),
		.CW        (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	rtwa_ring_mem #(
		.DEPTH(RING_DEPTH),
		.AW   (AW)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
`default_nettype wire
